// ----- rtl/core/bad_pkg.sv -----
// Package for the box average downscaler: constants, types, command structs.
// Used by the controller, datapath, top level and testbench; no dependencies.
package bad_pkg;

  localparam int unsigned MaxPixels  = 65536;
  localparam int unsigned MaxBoxSide = 16;

  localparam logic [10:0] SrcWidthRst  = 11'd256;
  localparam logic [10:0] SrcHeightRst = 11'd256;
  localparam logic [12:0] RatioRst     = 13'd256;

  localparam logic [1:0] RegSrcWidth  = 2'd0;
  localparam logic [1:0] RegSrcHeight = 2'd1;
  localparam logic [1:0] RegRatioX    = 2'd2;
  localparam logic [1:0] RegRatioY    = 2'd3;

  localparam logic ReqLoad    = 1'b0;
  localparam logic ReqAverage = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StScan,
    StDrain,
    StPrep,
    StDivide,
    StOut
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic setup;      // latch request, compute box origin
    logic scan_step;  // issue one box read, advance position
    logic accum;      // accumulate the read issued in the previous cycle
    logic div_start;  // load divider with the final sums
    logic div_step;   // one quotient bit
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // current position is the last of the box
    logic div_done;   // quotient complete
  } dp_sts_t;

endpackage

// ----- rtl/core/bad_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bad_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/core/bad_ctrl.sv -----
// Controller for the box average downscaler: sequences setup, box scan,
// division and result handoff. Depends on bad_pkg.
module bad_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_fire_i,
  input  logic             req_avg_i,
  input  logic             out_ready_i,
  input  bad_pkg::dp_sts_t sts_i,
  output bad_pkg::dp_cmd_t cmd_o,
  output logic             in_ready_o,
  output logic             out_valid_o
);
  bad_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bad_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      bad_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (req_fire_i && req_avg_i) begin
          cmd_o.setup = 1'b1;
          state_d     = bad_pkg::StSetup;
        end
      end
      bad_pkg::StSetup: begin
        state_d = bad_pkg::StScan;
      end
      bad_pkg::StScan: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.accum     = 1'b1;
        if (sts_i.scan_last) begin
          state_d = bad_pkg::StDrain;
        end
      end
      bad_pkg::StDrain: begin
        // add the last read before the sums go to the divider
        cmd_o.accum = 1'b1;
        state_d     = bad_pkg::StPrep;
      end
      bad_pkg::StPrep: begin
        cmd_o.div_start = 1'b1;
        state_d         = bad_pkg::StDivide;
      end
      bad_pkg::StDivide: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = bad_pkg::StOut;
        end
      end
      bad_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = bad_pkg::StIdle;
        end
      end
      default: state_d = bad_pkg::StIdle;
    endcase
  end
endmodule

// ----- rtl/core/bad_dp.sv -----
// Datapath for the box average downscaler: box address generation, pixel
// memory, accumulators and three radix-2 dividers sharing a step counter. Depends on bad_pkg, bad_ram.
module bad_dp #(
  parameter int unsigned MaxPixels  = bad_pkg::MaxPixels,
  parameter int unsigned MaxBoxSide = bad_pkg::MaxBoxSide
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [10:0]      src_width_i,
  input  logic [10:0]      src_height_i,
  input  logic [12:0]      ratio_x_i,
  input  logic [12:0]      ratio_y_i,
  input  logic             load_i,
  input  logic [15:0]      pixel_index_i,
  input  logic [23:0]      pixel_i,
  input  logic [9:0]       out_x_i,
  input  logic [9:0]       out_y_i,
  input  bad_pkg::dp_cmd_t cmd_i,
  output bad_pkg::dp_sts_t sts_o,
  output logic [7:0]       avg_red_o,
  output logic [7:0]       avg_green_o,
  output logic [7:0]       avg_blue_o,
  output logic [8:0]       box_count_o
);
  localparam int unsigned AddrW = $clog2(MaxPixels);
  localparam int unsigned SideW = $clog2(MaxBoxSide + 1);
  localparam int unsigned CntW  = 2 * SideW;
  localparam int unsigned SumW  = CntW + 8;
  localparam int unsigned IdxW  = 32;
  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [22:0]     x0_q, y0_q;
  logic [SideW-1:0] wx_q, wy_q, i_q, j_q;
  logic [21:0]     limit_q;
  logic [IdxW-1:0] idx_c;
  logic            hit_c, hit_q;
  logic [SumW-1:0] sr_q, sg_q, sb_q;
  logic [CntW-1:0] cnt_q;
  logic [23:0]     rdata;
  logic [13:0]     sx_raw, sy_raw;
  logic [SideW-1:0] wx_c, wy_c;
  logic [23:0]     x0_c, y0_c;
  logic            we_c;

  // ceil(ratio) limited to the maximum box side
  assign sx_raw = 14'(ratio_x_i) + 14'd255;
  assign sy_raw = 14'(ratio_y_i) + 14'd255;
  assign wx_c = (7'(sx_raw[13:8]) > 7'(MaxBoxSide)) ? SideW'(MaxBoxSide)
                                                      : SideW'(sx_raw[13:8]);
  assign wy_c = (7'(sy_raw[13:8]) > 7'(MaxBoxSide)) ? SideW'(MaxBoxSide)
                                                      : SideW'(sy_raw[13:8]);
  assign x0_c = 24'(out_x_i) * 24'(ratio_x_i);
  assign y0_c = 24'(out_y_i) * 24'(ratio_y_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      x0_q    <= 23'(x0_c[23:8]);
      y0_q    <= 23'(y0_c[23:8]);
      wx_q    <= wx_c;
      wy_q    <= wy_c;
      limit_q <= 22'(src_width_i) * 22'(src_height_i);
      i_q     <= '0;
      j_q     <= '0;
    end else if (cmd_i.scan_step) begin
      if (j_q + SideW'(1) >= wy_q) begin
        j_q <= '0;
        i_q <= i_q + SideW'(1);
      end else begin
        j_q <= j_q + SideW'(1);
      end
    end
  end

  // box pixel index; a zero side means an empty box
  assign idx_c = IdxW'(x0_q + 23'(i_q)) + IdxW'(y0_q + 23'(j_q)) * IdxW'(src_width_i);
  assign hit_c = cmd_i.scan_step && (wx_q != '0) && (wy_q != '0) &&
                 (idx_c < IdxW'(limit_q)) && (idx_c < IdxW'(MaxPixels));
  assign sts_o.scan_last = (i_q + SideW'(1) >= wx_q) && (j_q + SideW'(1) >= wy_q);

  // drop loads past the memory
  assign we_c = load_i && (32'(pixel_index_i) < MaxPixels);

  bad_ram #(.Width(24), .Depth(MaxPixels)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we_c),
    .waddr_i (AddrW'(pixel_index_i)),
    .wdata_i (pixel_i),
    .raddr_i (idx_c[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      sr_q <= '0; sg_q <= '0; sb_q <= '0; cnt_q <= '0;
    end else if (cmd_i.accum && hit_q) begin
      sr_q  <= sr_q + SumW'(rdata[23:16]);
      sg_q  <= sg_q + SumW'(rdata[15:8]);
      sb_q  <= sb_q + SumW'(rdata[7:0]);
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // three restoring dividers sharing one step counter
  logic [SumW-1:0] qr_q, qg_q, qb_q;
  logic [CntW:0]   rr_q, rg_q, rb_q;
  logic [StepW-1:0] step_q;
  logic [CntW:0]   tr, tg, tb;

  assign tr = {rr_q[CntW-1:0], qr_q[SumW-1]};
  assign tg = {rg_q[CntW-1:0], qg_q[SumW-1]};
  assign tb = {rb_q[CntW-1:0], qb_q[SumW-1]};
  assign sts_o.div_done = (step_q == StepW'(SumW));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      step_q <= '0;
      rr_q <= '0; rg_q <= '0; rb_q <= '0;
    end else if (cmd_i.div_step && !sts_o.div_done) begin
      step_q <= step_q + StepW'(1);
      if (tr >= (CntW+1)'(cnt_q)) begin
        rr_q <= tr - (CntW+1)'(cnt_q); qr_q <= {qr_q[SumW-2:0], 1'b1};
      end else begin
        rr_q <= tr; qr_q <= {qr_q[SumW-2:0], 1'b0};
      end
      if (tg >= (CntW+1)'(cnt_q)) begin
        rg_q <= tg - (CntW+1)'(cnt_q); qg_q <= {qg_q[SumW-2:0], 1'b1};
      end else begin
        rg_q <= tg; qg_q <= {qg_q[SumW-2:0], 1'b0};
      end
      if (tb >= (CntW+1)'(cnt_q)) begin
        rb_q <= tb - (CntW+1)'(cnt_q); qb_q <= {qb_q[SumW-2:0], 1'b1};
      end else begin
        rb_q <= tb; qb_q <= {qb_q[SumW-2:0], 1'b0};
      end
    end
    if (cmd_i.div_start) begin
      qr_q <= sr_q; qg_q <= sg_q; qb_q <= sb_q;
    end
  end

  always_comb begin
    if (cnt_q == '0) begin
      avg_red_o = '0; avg_green_o = '0; avg_blue_o = '0; box_count_o = '0;
    end else begin
      avg_red_o   = qr_q[7:0];
      avg_green_o = qg_q[7:0];
      avg_blue_o  = qb_q[7:0];
      box_count_o = (cnt_q > CntW'(511)) ? 9'd511 : 9'(cnt_q);
    end
  end
endmodule

// ----- rtl/core/box_average_downscaler_unit.sv -----
// Box average downscaler top level: config registers, controller, datapath.
// A load is written to memory when it is taken. A request runs setup,
// N = max(1, wx)*max(1, wy) box reads at one per cycle, drain, divider load and 18 divider
// steps before m_axis_tvalid rises; input waits until the result is taken. Reset (async,
// active low) restores config, idles the controller; memory kept.
module box_average_downscaler_unit #(
  parameter int unsigned MaxPixels  = bad_pkg::MaxPixels,
  parameter int unsigned MaxBoxSide = bad_pkg::MaxBoxSide
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tuser,  // req_type
  input  logic [63:0] s_axis_tdata,  // pixel_index, red_in, green_in, blue_in, out_x, out_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // avg_red, avg_green, avg_blue, box_count
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  logic [10:0] src_width_q, src_height_q;
  logic [12:0] ratio_x_q, ratio_y_q;
  logic        fire, req_avg;
  bad_pkg::dp_cmd_t cmd;
  bad_pkg::dp_sts_t sts;
  logic [7:0] avg_r, avg_g, avg_b;
  logic [8:0] cnt;

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bad_pkg::SrcWidthRst;
      src_height_q <= bad_pkg::SrcHeightRst;
      ratio_x_q    <= bad_pkg::RatioRst;
      ratio_y_q    <= bad_pkg::RatioRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bad_pkg::RegSrcWidth:  src_width_q  <= cfg_data_i[10:0];
        bad_pkg::RegSrcHeight: src_height_q <= cfg_data_i[10:0];
        bad_pkg::RegRatioX:    ratio_x_q    <= cfg_data_i;
        bad_pkg::RegRatioY:    ratio_y_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign fire    = s_axis_tvalid && s_axis_tready;
  assign req_avg = (s_axis_tuser[0] == bad_pkg::ReqAverage);

  bad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_fire_i  (fire),
    .req_avg_i   (req_avg),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid)
  );

  // pack the pixel as red, green, blue from the top bits down
  bad_dp #(.MaxPixels(MaxPixels), .MaxBoxSide(MaxBoxSide)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .src_width_i   (src_width_q),
    .src_height_i  (src_height_q),
    .ratio_x_i     (ratio_x_q),
    .ratio_y_i     (ratio_y_q),
    .load_i        (fire && !req_avg),
    .pixel_index_i (s_axis_tdata[15:0]),
    .pixel_i       ({s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
    .out_x_i       (s_axis_tdata[49:40]),
    .out_y_i       (s_axis_tdata[59:50]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .avg_red_o     (avg_r),
    .avg_green_o   (avg_g),
    .avg_blue_o    (avg_b),
    .box_count_o   (cnt)
  );

  // tdata: avg_red in the lowest byte, box_count above the three means
  assign m_axis_tdata = {7'd0, cnt, avg_b, avg_g, avg_r};
endmodule

// ----- rtl/core/bad_checker.sv -----
// Port-level checker for the box average downscaler, bound to the top level.
// Depends on nothing beyond the top level's ports.
module bad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> s_axis_tready)
    else $error("load stalled input");
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready && !m_axis_tvalid)
    else $error("request not processed");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32:24] == 9'd0 |-> m_axis_tdata[23:0] == 24'd0)
    else $error("empty box with nonzero mean");
endmodule

bind box_average_downscaler_unit bad_checker u_bad_checker (.*);

// ----- sim/box_average_downscaler_unit_test.sv -----
// Testbench for box_average_downscaler_unit: loads pixels, requests box averages
// and checks every result against a scoreboard with its own image copy.
// Depends on bad_pkg and the box_average_downscaler_unit RTL.
`timescale 1ns / 100ps

class box_average_scoreboard;
  logic [23:0] image_mem [int];
  int unsigned width_px, height_px, ratio_x, ratio_y;
  logic [32:0] expected_avgs [$];
  int unsigned failures;
  int unsigned averages_checked;

  function new();
    width_px = 256; height_px = 256; ratio_x = 256; ratio_y = 256;
    failures = 0; averages_checked = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [12:0] val);
    case (idx)
      bad_pkg::RegSrcWidth:  width_px  = val[10:0];
      bad_pkg::RegSrcHeight: height_px = val[10:0];
      bad_pkg::RegRatioX:    ratio_x   = val;
      default:               ratio_y   = val;
    endcase
  endfunction

  static function int unsigned side_of(int unsigned r);
    int unsigned s;
    s = (r + 255) >> 8;
    return (s > bad_pkg::MaxBoxSide) ? bad_pkg::MaxBoxSide : s;
  endfunction

  // Note an accepted request: update the image on a load, predict an average.
  function void note_request(logic kind, logic [15:0] pidx, logic [7:0] r,
                             logic [7:0] g, logic [7:0] b,
                             logic [9:0] ox, logic [9:0] oy);
    longint unsigned x0, y0, lim, idx;
    int unsigned wx, wy, sr, sg, sb, cnt;
    logic [23:0] p;
    if (kind == bad_pkg::ReqLoad) begin
      image_mem[pidx] = {r, g, b};
      return;
    end
    x0 = (longint'(ox) * ratio_x) >> 8;
    y0 = (longint'(oy) * ratio_y) >> 8;
    wx = side_of(ratio_x); wy = side_of(ratio_y);
    lim = longint'(width_px) * height_px;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int i = 0; i < wx; i++)
      for (int j = 0; j < wy; j++) begin
        idx = (x0 + i) + (y0 + j) * width_px;
        if (idx >= lim || idx >= bad_pkg::MaxPixels) continue;
        p = image_mem.exists(idx) ? image_mem[idx] : 24'h0;
        sr += p[23:16]; sg += p[15:8]; sb += p[7:0]; cnt++;
      end
    if (cnt == 0) expected_avgs.push_back(33'h0);
    else expected_avgs.push_back({8'(sr / cnt), 8'(sg / cnt), 8'(sb / cnt),
                                  9'((cnt > 511) ? 511 : cnt)});
  endfunction

  // Compare one accepted result with the oldest prediction.
  function void check_result(logic [39:0] data);
    logic [32:0] e, a;
    a = {data[7:0], data[15:8], data[23:16], data[32:24]};
    if (expected_avgs.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, a);
      failures++;
      return;
    end
    e = expected_avgs.pop_front();
    averages_checked++;
    if (e[32:25] !== a[32:25]) begin
      $display("%0t: avg_red expected %0d actual %0d", $time, e[32:25], a[32:25]);
      failures++;
    end
    if (e[24:17] !== a[24:17]) begin
      $display("%0t: avg_green expected %0d actual %0d", $time, e[24:17], a[24:17]);
      failures++;
    end
    if (e[16:9] !== a[16:9]) begin
      $display("%0t: avg_blue expected %0d actual %0d", $time, e[16:9], a[16:9]);
      failures++;
    end
    if (e[8:0] !== a[8:0]) begin
      $display("%0t: box_count expected %0d actual %0d", $time, e[8:0], a[8:0]);
      failures++;
    end
  endfunction
endclass

module box_average_downscaler_unit_test;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [7:0]  s_axis_tuser;   // req_type
  logic [63:0] s_axis_tdata;   // pixel_index, red_in, green_in, blue_in, out_x, out_y
  logic        m_axis_tvalid, m_axis_tready;
  logic [39:0] m_axis_tdata;   // avg_red, avg_green, avg_blue, box_count
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [12:0] cfg_data_i;

  box_average_scoreboard board;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned requests_sent;
  int unsigned phase_width;

  box_average_downscaler_unit u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("box_average_downscaler_unit: mismatch");
    $finish;
  end

  // Receiver: stall at random, check each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Send one request; hold it until the block accepts it.
  task automatic send_request(logic kind, logic [15:0] pidx, logic [7:0] r,
                              logic [7:0] g, logic [7:0] b,
                              logic [9:0] ox, logic [9:0] oy);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {7'b0, kind};
    s_axis_tdata  <= {4'b0, oy, ox, b, g, r, pidx};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(kind, pidx, r, g, b, ox, oy);
    if (kind == bad_pkg::ReqAverage) requests_sent++;
  endtask

  task automatic load_pixel(logic [15:0] pidx);
    send_request(bad_pkg::ReqLoad, pidx, 8'($urandom), 8'($urandom), 8'($urandom),
                 10'($urandom), 10'($urandom));
  endtask

  task automatic average_at(logic [9:0] ox, logic [9:0] oy);
    send_request(bad_pkg::ReqAverage, 16'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), ox, oy);
  endtask

  // Drop the request line, wait for every prediction, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.expected_avgs.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // Fill the first 256 entries; the image settings of the random phases stay within them.
  task automatic fill_memory();
    for (int i = 0; i < 256; i++) load_pixel(i[15:0]);
  endtask

  // One random phase: mostly requests near the origin, some anywhere.
  task automatic random_phase(int unsigned n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(3) == 0) load_pixel(16'($urandom_range(255)));
      else if ($urandom_range(4) == 0) average_at(10'($urandom), 10'($urandom));
      else average_at(10'($urandom_range(63)), 10'($urandom_range(63)));
    end
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tuser = '0; s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = bad_pkg::RegSrcWidth; cfg_data_i = '0;
    send_idle_pct = 0; recv_idle_pct = 0; requests_sent = 0; phase_width = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fill_memory();

    // Directed: extremes of fields, unit ratios, wraparound, empty boxes.
    send_request(bad_pkg::ReqLoad, 16'd0, 8'hff, 8'h00, 8'hff, 10'h3ff, 10'h3ff);
    send_request(bad_pkg::ReqLoad, 16'hffff, 8'h00, 8'hff, 8'h00, 10'h0, 10'h0);
    average_at(10'd0, 10'd0);
    average_at(10'd255, 10'd255);           // last entry of the memory
    average_at(10'h3ff, 10'h3ff);           // past the image: empty box
    drain();
    write_reg(bad_pkg::RegSrcWidth, 13'd16);
    write_reg(bad_pkg::RegSrcHeight, 13'd16);
    write_reg(bad_pkg::RegRatioX, 13'd4096); // 16x16 box, full count
    write_reg(bad_pkg::RegRatioY, 13'd4096);
    average_at(10'd0, 10'd0);
    average_at(10'd3, 10'd3);               // box past the image
    average_at(10'h3ff, 10'd0);
    drain();
    write_reg(bad_pkg::RegSrcWidth, 13'd1024);
    write_reg(bad_pkg::RegSrcHeight, 13'd1024);
    average_at(10'd0, 10'd1000);            // box beyond the memory
    drain();
    write_reg(bad_pkg::RegSrcWidth, 13'd1);
    write_reg(bad_pkg::RegSrcHeight, 13'd1);
    write_reg(bad_pkg::RegRatioX, 13'd1);
    write_reg(bad_pkg::RegRatioY, 13'd1);
    average_at(10'd0, 10'd0);
    average_at(10'd1, 10'd0);
    drain();
    write_reg(bad_pkg::RegSrcWidth, 13'd0);  // zero width: empty box
    average_at(10'd0, 10'd0);
    drain();
    write_reg(bad_pkg::RegSrcWidth, 13'd7);  // row wraps past the right edge
    write_reg(bad_pkg::RegSrcHeight, 13'd9);
    write_reg(bad_pkg::RegRatioX, 13'd640);
    write_reg(bad_pkg::RegRatioY, 13'd300);
    average_at(10'd2, 10'd1);
    average_at(10'd0, 10'd0);
    average_at(10'd5, 10'd10);
    drain();

    // Random phases over several settings and idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 6;  recv_idle_pct = 60; end
        1: begin send_idle_pct = 60; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_width = $urandom_range(1, 64);
      write_reg(bad_pkg::RegSrcWidth, 13'(phase_width));
      write_reg(bad_pkg::RegSrcHeight, 13'($urandom_range(1, 256 / phase_width)));
      write_reg(bad_pkg::RegRatioX,
                13'(($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 900)));
      write_reg(bad_pkg::RegRatioY,
                13'(($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 900)));
      random_phase(40);
      drain();
    end

    $display("covered %0d average requests over several image and ratio settings",
             requests_sent);
    $display("checked %0d averages, %0d failures", board.averages_checked,
             board.failures);
    if (board.failures == 0 && board.expected_avgs.size() == 0)
      $display("box_average_downscaler_unit: match");
    else
      $display("box_average_downscaler_unit: mismatch");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/bad_pkg.sv
rtl/core/bad_ram.sv
rtl/core/bad_ctrl.sv
rtl/core/bad_dp.sv
rtl/core/box_average_downscaler_unit.sv
rtl/core/bad_checker.sv
sim/box_average_downscaler_unit_test.sv
